FILE: sv/keyed_event_queue_defines.svh
// Assertion macros shared by the keyed event queue.
`ifndef KEYED_EVENT_QUEUE_DEFINES_SVH
`define KEYED_EVENT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define KEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_event_queue: check failed");

// Next-cycle implication, held off during reset.
`define KEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_event_queue: check failed");

`else

`define KEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/keq_pkg.sv
package keq_pkg;

    // Port field widths
    localparam int KEQ_CMD_W         = 2;
    localparam int KEQ_EVENT_KEY_W   = 16;
    localparam int KEQ_EVENT_PAY_W   = 32;
    localparam int KEQ_OCC_W         = 5;

    // Default sizing
    localparam int KEQ_DEPTH         = 16;
    localparam int KEQ_KEY_WIDTH     = 16;
    localparam int KEQ_PAYLOAD_WIDTH = 32;

    // Request commands
    typedef enum logic [KEQ_CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2
    } keq_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;   // latch request, clear result
        logic clr_idx;
        logic inc_idx;
        logic rd_en;      // read memory
        logic rd_next;    // read at idx+1 instead of idx
        logic capture;    // take read entry as the result
        logic push_wr;    // append request at tail
        logic shift_wr;   // move read entry down to idx
        logic set_ovf;
        logic dec_count;
        logic emit;       // present result beat
    } keq_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_push;
        logic is_remove;
        logic is_pop;
        logic full;
        logic empty;
        logic hit;        // read entry is the one to take
        logic last;       // idx+1 >= count
        logic next_last;  // idx+2 >= count
    } keq_stat_t;

endpackage

FILE: sv/keq_datapath.sv
module keq_datapath
    import keq_pkg::*;
#(
    parameter int DEPTH         = KEQ_DEPTH,
    parameter int KEY_WIDTH     = KEQ_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = KEQ_PAYLOAD_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  keq_ctl_t                   ctl,
    output keq_stat_t                  stat,
    input  logic [KEQ_CMD_W-1:0]       command,
    input  logic [KEQ_EVENT_KEY_W-1:0] event_key,
    input  logic [KEQ_EVENT_PAY_W-1:0] event_payload,
    output logic                       done,
    output logic                       found,
    output logic [KEQ_EVENT_KEY_W-1:0] out_key,
    output logic [KEQ_EVENT_PAY_W-1:0] out_payload,
    output logic                       overflow,
    output logic [KEQ_OCC_W-1:0]       occupancy
);

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CW1 = CW + 1;

    // Entry storage
    logic [KEY_WIDTH-1:0]     key_mem [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];

    logic [KEQ_CMD_W-1:0]     req_cmd_reg;
    logic [KEY_WIDTH-1:0]     req_key_reg;
    logic [PAYLOAD_WIDTH-1:0] req_pay_reg;

    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            idx_reg, idx_next;

    logic [KEY_WIDTH-1:0]     rd_key_reg;
    logic [PAYLOAD_WIDTH-1:0] rd_pay_reg;

    logic                     res_found_reg, res_ovf_reg;
    logic [KEY_WIDTH-1:0]     res_key_reg;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg;

    logic                       done_reg, found_reg, overflow_reg;
    logic [KEQ_EVENT_KEY_W-1:0] out_key_reg;
    logic [KEQ_EVENT_PAY_W-1:0] out_pay_reg;
    logic [KEQ_OCC_W-1:0]       occ_reg;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr, rd_addr;
    logic [KEY_WIDTH-1:0]     wr_key;
    logic [PAYLOAD_WIDTH-1:0] wr_pay;
    logic [CW1-1:0]           idx_ext;

    // Status decode
    assign idx_ext        = CW1'(idx_reg);
    assign stat.is_push   = (req_cmd_reg == CMD_PUSH);
    assign stat.is_remove = (req_cmd_reg == CMD_REMOVE);
    assign stat.is_pop    = (req_cmd_reg == CMD_POP);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.hit       = (req_cmd_reg == CMD_POP) || (rd_key_reg == req_key_reg);
    assign stat.last      = (idx_ext + CW1'(1)) >= CW1'(count_reg);
    assign stat.next_last = (idx_ext + CW1'(2)) >= CW1'(count_reg);

    // Counter and index next values
    always_comb
    begin
        count_next = count_reg;
        if (ctl.push_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.clr_idx)
        begin
            idx_next = '0;
        end
        else if (ctl.inc_idx)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    // Memory port muxing: push writes at the tail, a shift writes one slot down
    assign wr_en   = ctl.push_wr || ctl.shift_wr;
    assign wr_addr = ctl.push_wr ? count_reg[IW-1:0] : idx_reg;
    assign wr_key  = ctl.push_wr ? req_key_reg : rd_key_reg;
    assign wr_pay  = ctl.push_wr ? req_pay_reg : rd_pay_reg;
    assign rd_addr = ctl.rd_next ? (idx_reg + IW'(1)) : idx_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= ctl.emit;
        end
    end

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
    end

    // Request, result and output beat registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_cmd_reg   <= command;
            req_key_reg   <= KEY_WIDTH'(event_key);
            req_pay_reg   <= PAYLOAD_WIDTH'(event_payload);
            res_found_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
            res_key_reg   <= '0;
            res_pay_reg   <= '0;
        end
        else
        begin
            if (ctl.capture)
            begin
                res_found_reg <= 1'b1;
                res_key_reg   <= rd_key_reg;
                res_pay_reg   <= rd_pay_reg;
            end
            if (ctl.set_ovf)
            begin
                res_ovf_reg <= 1'b1;
            end
        end
        if (ctl.emit)
        begin
            found_reg    <= res_found_reg;
            overflow_reg <= res_ovf_reg;
            out_key_reg  <= KEQ_EVENT_KEY_W'(res_key_reg);
            out_pay_reg  <= KEQ_EVENT_PAY_W'(res_pay_reg);
            occ_reg      <= KEQ_OCC_W'(count_reg);
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign overflow    = overflow_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_pay_reg;
    assign occupancy   = occ_reg;

endmodule

FILE: sv/keq_ctrl.sv
module keq_ctrl
    import keq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  keq_stat_t stat,
    output keq_ctl_t  ctl
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_READ     = 7'b0000100,
        S_CMP      = 7'b0001000,
        S_SH_RD    = 7'b0010000,
        S_SH_WR    = 7'b0100000,
        S_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Sequencer: scan the entries, reading then comparing each, then compact by reading and writing each later entry
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                ctl.clr_idx = 1'b1;
                if (stat.is_push)
                begin
                    ctl.push_wr = !stat.full;
                    ctl.set_ovf = stat.full;
                    state_next  = S_RESULT;
                end
                else if ((stat.is_remove || stat.is_pop) && !stat.empty)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_READ:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.hit)
                begin
                    ctl.capture = 1'b1;
                    if (stat.last)
                    begin
                        ctl.dec_count = 1'b1;
                        state_next    = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (stat.last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    ctl.inc_idx = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_SH_RD:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_next = 1'b1;
                state_next  = S_SH_WR;
            end
            S_SH_WR:
            begin
                ctl.shift_wr = 1'b1;
                ctl.inc_idx  = 1'b1;
                if (stat.next_last)
                begin
                    ctl.dec_count = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_RESULT:
            begin
                ctl.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/keyed_event_queue.sv
// Keyed event queue: an ordered queue of (event id, payload) entries with push,
// remove-oldest-by-id and pop-oldest commands. A request is taken when start is
// high and busy is low; exactly one result beat follows, shown for one cycle
// with done high, and the receiver must take it then since it cannot stall.
// A push, or a request that finds nothing to scan, goes straight to its result;
// a remove reads and compares entries from the head up to the hit (or all on a
// miss), then moves each entry after the hit down one slot; a pop is a remove
// that hits at the head. The entry memory has a registered read port, used for
// every entry visited in both scan and compaction.
module keyed_event_queue
    import keq_pkg::*;
#(
    parameter int DEPTH         = KEQ_DEPTH,
    parameter int KEY_WIDTH     = KEQ_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = KEQ_PAYLOAD_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [KEQ_CMD_W-1:0]       command,
    input  logic [KEQ_EVENT_KEY_W-1:0] event_key,
    input  logic [KEQ_EVENT_PAY_W-1:0] event_payload,
    output logic                       done,
    output logic                       found,
    output logic [KEQ_EVENT_KEY_W-1:0] out_key,
    output logic [KEQ_EVENT_PAY_W-1:0] out_payload,
    output logic                       overflow,
    output logic [KEQ_OCC_W-1:0]       occupancy
);

`include "keyed_event_queue_defines.svh"

    keq_ctl_t  ctl;
    keq_stat_t stat;

    keq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    keq_datapath #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .command       (command),
        .event_key     (event_key),
        .event_payload (event_payload),
        .done          (done),
        .found         (found),
        .out_key       (out_key),
        .out_payload   (out_payload),
        .overflow      (overflow),
        .occupancy     (occupancy)
    );

    // A result beat closes the request, so the block is free again
    `KEQ_ASSERT_IMPLY(a_done_frees, clk, rst_n, done, !busy)
    // An accepted request always holds the block busy on the next cycle
    `KEQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    // A dropped push only happens on a full queue
    `KEQ_ASSERT_IMPLY(a_ovf_full, clk, rst_n, done && overflow, occupancy == KEQ_OCC_W'(DEPTH))
    // A returned entry and a dropped push never share a beat
    `KEQ_ASSERT_IMPLY(a_found_xor_ovf, clk, rst_n, done && found, !overflow)

endmodule

FILE: tb/keq_reply_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the keyed event queue, keeps its
// own copy of the queue, and compares every result beat with the oldest
// predicted reply.
module keq_reply_checker
    import keq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [KEQ_CMD_W-1:0]       command,
    input  logic [KEQ_EVENT_KEY_W-1:0] event_key,
    input  logic [KEQ_EVENT_PAY_W-1:0] event_payload,
    input  logic                       done,
    input  logic                       found,
    input  logic [KEQ_EVENT_KEY_W-1:0] out_key,
    input  logic [KEQ_EVENT_PAY_W-1:0] out_payload,
    input  logic                       overflow,
    input  logic [KEQ_OCC_W-1:0]       occupancy,
    output int                         fail_count,
    output int                         pending,
    output int                         taken_count,
    output int                         drop_count
);

    localparam int REPLY_SLOTS = 16;

    typedef struct packed {
        logic                       found;
        logic [KEQ_EVENT_KEY_W-1:0] key;
        logic [KEQ_EVENT_PAY_W-1:0] payload;
        logic                       overflow;
        logic [KEQ_OCC_W-1:0]       occupancy;
    } queue_reply_t;

    // Shadow copy of the queue, slot 0 oldest
    logic [KEQ_EVENT_KEY_W-1:0] shadow_keys [KEQ_DEPTH];
    logic [KEQ_EVENT_PAY_W-1:0] shadow_pays [KEQ_DEPTH];
    int                         shadow_count;

    // Predicted replies in order, kept as a ring
    queue_reply_t replies_due [REPLY_SLOTS];
    int           due_head;
    int           due_count;
    int           fails = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        fails++;
    endtask

    // Take out the entry at slot and close the gap behind it
    task automatic take_entry(input int slot, inout queue_reply_t reply);
        reply.found   = 1'b1;
        reply.key     = shadow_keys[slot];
        reply.payload = shadow_pays[slot];
        for (int j = slot; j + 1 < shadow_count; j++)
        begin
            shadow_keys[j] = shadow_keys[j + 1];
            shadow_pays[j] = shadow_pays[j + 1];
        end
        shadow_count--;
    endtask

    // Work out the reply to one accepted request and update the shadow queue
    task automatic apply_request(input logic [KEQ_CMD_W-1:0] cmd,
                                 input logic [KEQ_EVENT_KEY_W-1:0] key,
                                 input logic [KEQ_EVENT_PAY_W-1:0] pay,
                                 output queue_reply_t reply);
        reply = '0;
        case (cmd)
            CMD_PUSH:
            begin
                if (shadow_count < KEQ_DEPTH)
                begin
                    shadow_keys[shadow_count] = key;
                    shadow_pays[shadow_count] = pay;
                    shadow_count++;
                end
                else
                begin
                    reply.overflow = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_keys[i] == key)
                    begin
                        take_entry(i, reply);
                        break;
                    end
                end
            end
            CMD_POP:
            begin
                if (shadow_count != 0)
                    take_entry(0, reply);
            end
            default:
            begin
                // unused code: queue left alone
            end
        endcase
        reply.occupancy = KEQ_OCC_W'(shadow_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_reply_t want;
        queue_reply_t next_reply;
        if (!rst_n)
        begin
            shadow_count = 0;
            due_head     = 0;
            due_count    = 0;
            pending     <= 0;
            taken_count <= 0;
            drop_count  <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (done)
            begin
                if (due_count == 0)
                begin
                    report_mismatch("result beat with nothing outstanding, occupancy",
                                    64'(occupancy), 64'(0));
                end
                else
                begin
                    want      = replies_due[due_head];
                    due_head  = (due_head + 1) % REPLY_SLOTS;
                    due_count = due_count - 1;
                    if (found !== want.found)
                        report_mismatch("found", 64'(found), 64'(want.found));
                    if (out_key !== want.key)
                        report_mismatch("out_key", 64'(out_key), 64'(want.key));
                    if (out_payload !== want.payload)
                        report_mismatch("out_payload", 64'(out_payload), 64'(want.payload));
                    if (overflow !== want.overflow)
                        report_mismatch("overflow", 64'(overflow), 64'(want.overflow));
                    if (occupancy !== want.occupancy)
                        report_mismatch("occupancy", 64'(occupancy), 64'(want.occupancy));
                end
            end
            // request beat
            if (start && !busy)
            begin
                apply_request(command, event_key, event_payload, next_reply);
                if (due_count == REPLY_SLOTS)
                begin
                    report_mismatch("requests outstanding beyond tracking, count",
                                    64'(due_count), 64'(REPLY_SLOTS - 1));
                end
                else
                begin
                    replies_due[(due_head + due_count) % REPLY_SLOTS] = next_reply;
                    due_count = due_count + 1;
                end
                if (next_reply.found)
                    taken_count <= taken_count + 1;
                if (next_reply.overflow)
                    drop_count <= drop_count + 1;
            end
            pending <= due_count;
        end
        fail_count <= fails;
    end

endmodule

FILE: tb/keyed_event_queue_tb.sv
`timescale 1ns / 1ps

module keyed_event_queue_tb;
    import keq_pkg::*;

    localparam logic [KEQ_CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 360;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       start         = 1'b0;
    logic [KEQ_CMD_W-1:0]       command       = '0;
    logic [KEQ_EVENT_KEY_W-1:0] event_key     = '0;
    logic [KEQ_EVENT_PAY_W-1:0] event_payload = '0;
    logic                       busy;
    logic                       done;
    logic                       found;
    logic [KEQ_EVENT_KEY_W-1:0] out_key;
    logic [KEQ_EVENT_PAY_W-1:0] out_payload;
    logic                       overflow;
    logic [KEQ_OCC_W-1:0]       occupancy;

    int fail_count;
    int pending;
    int taken_count;
    int drop_count;
    int cycle_count = 0;
    int items_sent  = 0;

    keyed_event_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .event_key     (event_key),
        .event_payload (event_payload),
        .done          (done),
        .found         (found),
        .out_key       (out_key),
        .out_payload   (out_payload),
        .overflow      (overflow),
        .occupancy     (occupancy)
    );

    keq_reply_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .event_key     (event_key),
        .event_payload (event_payload),
        .done          (done),
        .found         (found),
        .out_key       (out_key),
        .out_payload   (out_payload),
        .overflow      (overflow),
        .occupancy     (occupancy),
        .fail_count    (fail_count),
        .pending       (pending),
        .taken_count   (taken_count),
        .drop_count    (drop_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one request beat and hold it until the block takes it
    task automatic send_request(input logic [KEQ_CMD_W-1:0] cmd,
                                input logic [KEQ_EVENT_KEY_W-1:0] key,
                                input logic [KEQ_EVENT_PAY_W-1:0] pay);
        start         <= 1'b1;
        command       <= cmd;
        event_key     <= key;
        event_payload <= pay;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic sit_idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_gap(input int idle_pct);
        if ($urandom_range(99) < idle_pct)
            sit_idle($urandom_range(1, 12));
    endtask

    // Hold off until every predicted reply has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Random request; small key pool so removes hit often
    task automatic random_request(input int push_pct);
        int                         roll;
        logic [KEQ_CMD_W-1:0]       cmd;
        logic [KEQ_EVENT_KEY_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < 3)
            cmd = CMD_UNUSED;
        else if (roll < 3 + push_pct * 97 / 100)
            cmd = CMD_PUSH;
        else if ($urandom_range(1) == 1)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_POP;
        if ($urandom_range(3) == 0)
            key = KEQ_EVENT_KEY_W'($urandom);
        else
            key = KEQ_EVENT_KEY_W'($urandom_range(7));
        send_request(cmd, key, $urandom);
    endtask

    initial
    begin
        int idle_mix [4];
        int push_pct;
        idle_mix = '{0, 87, 0, 27};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: pop, remove, unused code
        send_request(CMD_POP, '0, '0);
        send_request(CMD_REMOVE, '0, '0);
        send_request(CMD_UNUSED, 16'h5a5a, 32'ha5a5_a5a5);

        // fill to the brim with extreme and repeated keys
        for (int i = 0; i < KEQ_DEPTH; i++)
        begin
            if (i == 0)
                send_request(CMD_PUSH, '0, '0);
            else if (i == 1)
                send_request(CMD_PUSH, '1, '1);
            else if (i == KEQ_DEPTH - 1)
                send_request(CMD_PUSH, 16'habcd, $urandom);
            else
                send_request(CMD_PUSH, KEQ_EVENT_KEY_W'(i % 3), $urandom);
        end

        // push on full drops, unused code on full
        send_request(CMD_PUSH, 16'h7777, 32'h1234_5678);
        send_request(CMD_UNUSED, '1, '1);

        // oldest duplicate, tail entry, miss, head by key, then pop
        send_request(CMD_REMOVE, 16'h0002, '0);
        send_request(CMD_REMOVE, 16'habcd, '0);
        send_request(CMD_REMOVE, 16'h1234, '0);
        send_request(CMD_REMOVE, 16'h0000, '0);
        send_request(CMD_POP, '1, '1);
        wait_drained();

        // random phases, one per entry of the sender idle mix
        foreach (idle_mix[p])
        begin
            push_pct = 50;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // swing between filling and draining so full and empty both come up
                if (i % 40 == 0)
                begin
                    case ($urandom_range(2))
                        0: push_pct = 25;
                        1: push_pct = 55;
                        default: push_pct = 85;
                    endcase
                end
                random_request(push_pct);
                maybe_gap(idle_mix[p]);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d requests under four idle mixes, %0d entries returned,",
                 items_sent, taken_count);
        $display("summary: %0d pushes dropped on a full queue", drop_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
